### design/idp_pkg.sv
`default_nettype none

package idp_pkg;

   // field and datapath widths
   localparam int CHAR_W   = 8;
   localparam int WHOLE_W  = 40;
   localparam int FRAC_W   = 30;
   localparam int CNT_W    = 4;
   localparam int SECS_W   = 25;
   localparam int VAL_W    = 63;
   localparam int DUR_W    = 64;
   localparam int TDATA_IN_W  = 8;
   localparam int TDATA_OUT_W = 64;
   localparam int TUSER_OUT_W = 2;

   // fraction digits kept after the decimal mark (0 to 9)
   localparam logic [CNT_W-1:0] FRACTION_DIGITS = 4'd9;
   localparam logic [CNT_W-1:0] MAX_FRAC_DIGITS = 4'd9;

   localparam logic [WHOLE_W-1:0] WHOLE_MAX  = {WHOLE_W{1'b1}};
   localparam logic [VAL_W-1:0]   TOTAL_MAX  = {VAL_W{1'b1}};
   // nanoseconds in one second
   localparam logic [FRAC_W-1:0]  NS_SCALE   = 30'd1_000_000_000;

   // unit lengths in seconds
   localparam logic [SECS_W-1:0] SECS_YEAR   = 25'd31_536_000;
   localparam logic [SECS_W-1:0] SECS_MONTH  = 25'd2_592_000;
   localparam logic [SECS_W-1:0] SECS_WEEK   = 25'd604_800;
   localparam logic [SECS_W-1:0] SECS_DAY    = 25'd86_400;
   localparam logic [SECS_W-1:0] SECS_HOUR   = 25'd3_600;
   localparam logic [SECS_W-1:0] SECS_MINUTE = 25'd60;
   localparam logic [SECS_W-1:0] SECS_SECOND = 25'd1;

   // per-word control that rides along the pipeline
   typedef struct packed {
      logic tv;     // this word closed a number-unit pair
      logic last;   // final character of the string
      logic neg;    // leading minus seen
      logic clamp;  // some saturation happened on this word
   } ctl_type;

   // parsed number-unit pair leaving the parser
   typedef struct packed {
      ctl_type              ctl;
      logic [WHOLE_W-1:0]   whole;
      logic [FRAC_W-1:0]    frac;
      logic [CNT_W-1:0]     cnt;
      logic [SECS_W-1:0]    secs;
   } parse_term_type;

   // scaled pair in nanoseconds, ready to accumulate
   typedef struct packed {
      ctl_type            ctl;
      logic [VAL_W-1:0]   value;
   } value_term_type;

   // power of ten for scaling a fraction up to nanoseconds
   function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] idx);
      logic [FRAC_W-1:0] r;
      case (idx)
         4'd0:    r = 30'd1;
         4'd1:    r = 30'd10;
         4'd2:    r = 30'd100;
         4'd3:    r = 30'd1_000;
         4'd4:    r = 30'd10_000;
         4'd5:    r = 30'd100_000;
         4'd6:    r = 30'd1_000_000;
         4'd7:    r = 30'd10_000_000;
         4'd8:    r = 30'd100_000_000;
         4'd9:    r = 30'd1_000_000_000;
         default: r = 30'd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### design/idp_parse.sv
`default_nettype none

module idp_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          req_tvalid,
   input  wire logic [idp_pkg::CHAR_W-1:0]    char_code,
   input  wire logic                          last_char,
   output logic                               a_valid_ff,
   output idp_pkg::parse_term_type            a_term_ff
);
   import idp_pkg::*;

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_WANT_P = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
   localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
   localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;
   localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
   localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
   localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
   localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
   localparam logic [CHAR_W-1:0] CH_S     = 8'h53;

   logic [1:0]          phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic                time_ff, time_in;
   logic                started_ff, started_in;
   logic                mark_ff, mark_in;
   logic [WHOLE_W-1:0]  whole_ff, whole_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                accept;
   logic                is_digit;
   logic [3:0]          digit;
   logic [WHOLE_W+3:0]  whole_ext;
   logic [WHOLE_W+3:0]  whole_x10;
   logic [FRAC_W-1:0]   frac_x10;
   logic [SECS_W-1:0]   unit_secs;
   parse_term_type      a_term_in;

   assign accept    = req_tvalid && adv;
   assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit     = 4'(char_code - CH_ZERO);
   assign whole_ext = {4'b0, whole_ff};
   assign whole_x10 = (whole_ext << 3) + (whole_ext << 1) + (WHOLE_W+4)'(digit);
   assign frac_x10  = (frac_ff << 3) + (frac_ff << 1) + FRAC_W'(digit);

   // unit letter to seconds; zero means no unit
   always_comb begin
      unique case (char_code)
         CH_Y:    unit_secs = SECS_YEAR;
         CH_M:    unit_secs = time_ff ? SECS_MINUTE : SECS_MONTH;
         CH_W:    unit_secs = SECS_WEEK;
         CH_D:    unit_secs = SECS_DAY;
         CH_H:    unit_secs = SECS_HOUR;
         CH_S:    unit_secs = SECS_SECOND;
         default: unit_secs = '0;
      endcase
   end

   // character decode and number build-up
   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      time_in    = time_ff;
      started_in = started_ff;
      mark_in    = mark_ff;
      whole_in   = whole_ff;
      frac_in    = frac_ff;
      cnt_in     = cnt_ff;

      a_term_in.ctl.tv    = 1'b0;
      a_term_in.ctl.last  = last_char;
      a_term_in.ctl.clamp = 1'b0;
      a_term_in.whole     = whole_ff;
      a_term_in.frac      = frac_ff;
      a_term_in.cnt       = cnt_ff;
      a_term_in.secs      = unit_secs;

      unique case (phase_ff)
         PH_START: begin
            if (char_code == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_WANT_P;
            end else if (char_code == CH_P) begin
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_HALT;
            end
         end
         PH_WANT_P: begin
            phase_in = (char_code == CH_P) ? PH_BODY : PH_HALT;
         end
         PH_BODY: begin
            if (is_digit) begin
               started_in = 1'b1;
               if (!mark_ff) begin
                  if (whole_x10 > {4'b0, WHOLE_MAX}) begin
                     whole_in            = WHOLE_MAX;
                     a_term_in.ctl.clamp = 1'b1;
                  end else begin
                     whole_in = whole_x10[WHOLE_W-1:0];
                  end
               end else if (cnt_ff < FRACTION_DIGITS && cnt_ff < MAX_FRAC_DIGITS) begin
                  frac_in = frac_x10;
                  cnt_in  = cnt_ff + 4'd1;
               end
            end else if ((char_code == CH_DOT || char_code == CH_COMMA) && !mark_ff) begin
               mark_in    = 1'b1;
               started_in = 1'b1;
            end else if (!started_ff) begin
               if (char_code == CH_T) begin
                  time_in = 1'b1;
               end else begin
                  phase_in = PH_HALT;
               end
            end else if (unit_secs == '0) begin
               phase_in = PH_HALT;
            end else begin
               // number-unit pair complete: hand it on, start a new number
               a_term_in.ctl.tv = 1'b1;
               started_in       = 1'b0;
               mark_in          = 1'b0;
               whole_in         = '0;
               frac_in          = '0;
               cnt_in           = '0;
            end
         end
         PH_HALT: begin
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      a_term_in.ctl.neg = neg_in;

      // end of string: back to the starting state
      if (last_char) begin
         phase_in   = PH_START;
         neg_in     = 1'b0;
         time_in    = 1'b0;
         started_in = 1'b0;
         mark_in    = 1'b0;
         whole_in   = '0;
         frac_in    = '0;
         cnt_in     = '0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         neg_ff     <= 1'b0;
         time_ff    <= 1'b0;
         started_ff <= 1'b0;
         mark_ff    <= 1'b0;
         whole_ff   <= '0;
         frac_ff    <= '0;
         cnt_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         time_ff    <= time_in;
         started_ff <= started_in;
         mark_ff    <= mark_in;
         whole_ff   <= whole_in;
         frac_ff    <= frac_in;
         cnt_ff     <= cnt_in;
      end
   end

   // stage A register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_term_ff <= a_term_in;
      end
   end

endmodule

`default_nettype wire

### design/idp_scale.sv
`default_nettype none

module idp_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          a_valid,
   input  wire idp_pkg::parse_term_type       a_term,
   output logic                               e_valid_ff,
   output idp_pkg::value_term_type            e_term_ff
);
   import idp_pkg::*;

   // stage B: whole part and fraction to nanoseconds
   logic                b_valid_ff;
   ctl_type             b_ctl_ff;
   logic [61:0]         b_lo_ff, b_lo_in;
   logic [37:0]         b_hi_ff, b_hi_in;
   logic [FRAC_W-1:0]   b_frac_ff, b_frac_in;
   logic [SECS_W-1:0]   b_secs_ff;
   logic [59:0]         frac_prod;

   // stage C: saturated value in nanoseconds
   logic                c_valid_ff;
   ctl_type             c_ctl_ff, c_ctl_in;
   logic [VAL_W-1:0]    c_value_ff, c_value_in;
   logic [SECS_W-1:0]   c_secs_ff;
   logic [69:0]         wsum;
   logic [70:0]         vsum;
   logic                v_over;

   // stage D: value times unit seconds, two partial products
   logic                d_valid_ff;
   ctl_type             d_ctl_ff;
   logic [56:0]         d_lo_ff, d_lo_in;
   logic [55:0]         d_hi_ff, d_hi_in;

   // stage E: saturated pair total
   value_term_type      e_term_in;
   logic [87:0]         prod;
   logic                p_over;

   assign b_lo_in   = 62'(a_term.whole[31:0]) * 62'(NS_SCALE);
   assign b_hi_in   = 38'(a_term.whole[WHOLE_W-1:32]) * 38'(NS_SCALE);
   assign frac_prod = 60'(a_term.frac) * 60'(pow10(MAX_FRAC_DIGITS - a_term.cnt));
   assign b_frac_in = frac_prod[FRAC_W-1:0];

   assign wsum       = {b_hi_ff, 32'b0} + 70'(b_lo_ff);
   assign vsum       = 71'(wsum) + 71'(b_frac_ff);
   assign v_over     = vsum > 71'(TOTAL_MAX);
   assign c_value_in = v_over ? TOTAL_MAX : vsum[VAL_W-1:0];

   always_comb begin
      c_ctl_in       = b_ctl_ff;
      c_ctl_in.clamp = b_ctl_ff.clamp | (b_ctl_ff.tv & v_over);
   end

   assign d_lo_in = 57'(c_value_ff[31:0]) * 57'(c_secs_ff);
   assign d_hi_in = 56'(c_value_ff[VAL_W-1:32]) * 56'(c_secs_ff);

   assign prod   = {d_hi_ff, 32'b0} + 88'(d_lo_ff);
   assign p_over = prod > 88'(TOTAL_MAX);

   always_comb begin
      e_term_in.ctl       = d_ctl_ff;
      e_term_in.ctl.clamp = d_ctl_ff.clamp | (d_ctl_ff.tv & p_over);
      e_term_in.value     = p_over ? TOTAL_MAX : prod[VAL_W-1:0];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         b_ctl_ff   <= a_term.ctl;
         b_lo_ff    <= b_lo_in;
         b_hi_ff    <= b_hi_in;
         b_frac_ff  <= b_frac_in;
         b_secs_ff  <= a_term.secs;
         c_ctl_ff   <= c_ctl_in;
         c_value_ff <= c_value_in;
         c_secs_ff  <= b_secs_ff;
         d_ctl_ff   <= c_ctl_ff;
         d_lo_ff    <= d_lo_in;
         d_hi_ff    <= d_hi_in;
         e_term_ff  <= e_term_in;
      end
   end

endmodule

`default_nettype wire

### design/idp_accum.sv
`default_nettype none

module idp_accum (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                e_valid,
   input  wire idp_pkg::value_term_type             e_term,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [idp_pkg::TDATA_OUT_W-1:0]          rsp_tdata,
   output logic [idp_pkg::TUSER_OUT_W-1:0]          rsp_tuser
);
   import idp_pkg::*;

   logic [VAL_W-1:0]        total_ff, total_in;
   logic                    clamp_ff, clamp_in;
   logic                    seen_ff, seen_in;
   logic                    rsp_valid_ff;
   logic [TDATA_OUT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [TUSER_OUT_W-1:0]  rsp_user_ff, rsp_user_in;

   logic                    take;
   logic                    load;
   logic [VAL_W:0]          sum;
   logic                    add_over;
   logic [VAL_W-1:0]        acc_total;
   logic                    acc_clamp;
   logic                    acc_seen;

   assign take     = adv && e_valid;
   assign load     = take && e_term.ctl.last;
   assign sum      = {1'b0, total_ff} + {1'b0, e_term.value};
   assign add_over = sum[VAL_W];

   // running total, flags and the result word
   always_comb begin
      acc_total = total_ff;
      if (e_term.ctl.tv) begin
         acc_total = add_over ? TOTAL_MAX : sum[VAL_W-1:0];
      end
      acc_clamp = clamp_ff | e_term.ctl.clamp | (e_term.ctl.tv & add_over);
      acc_seen  = seen_ff | e_term.ctl.tv;

      if (acc_seen) begin
         rsp_data_in = e_term.ctl.neg ? DUR_W'(-{1'b0, acc_total}) : {1'b0, acc_total};
         rsp_user_in = {acc_clamp, 1'b1};
      end else begin
         rsp_data_in = '0;
         rsp_user_in = '0;
      end

      total_in = total_ff;
      clamp_in = clamp_ff;
      seen_in  = seen_ff;
      if (take) begin
         total_in = acc_total;
         clamp_in = acc_clamp;
         seen_in  = acc_seen;
         if (e_term.ctl.last) begin
            total_in = '0;
            clamp_in = 1'b0;
            seen_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         clamp_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         clamp_ff <= clamp_in;
         seen_ff  <= seen_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### design/iso_duration_parser.sv
// A final character word passes stages A, B, C, D and E, then the result register.
// Throughput: one character word per cycle unless stalled; the parser, two multiply
// stages per product and the accumulator all advance together whenever adv is high.
// Input stalls only while a final character sits before a result word not yet taken.
// Reset (synchronous, active high) clears the parser, every stage valid bit,
// the running total and the result valid flag; payload registers are not reset.
`default_nettype none

module iso_duration_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: [7:0] char_code
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [idp_pkg::TDATA_IN_W-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   // rsp_tdata: [63:0] duration in ns (signed)
   // rsp_tuser: [0] valid_res, [1] saturated
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [idp_pkg::TDATA_OUT_W-1:0]        rsp_tdata,
   output logic [idp_pkg::TUSER_OUT_W-1:0]        rsp_tuser
);
   import idp_pkg::*;

   logic              adv;
   logic              a_valid;
   parse_term_type    a_term;
   logic              e_valid;
   value_term_type    e_term;

   // whole pipeline holds only when a final word meets an untaken result
   assign adv        = !(e_valid && e_term.ctl.last && rsp_tvalid && !rsp_tready);
   assign req_tready = adv;

   idp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .char_code  (req_tdata[CHAR_W-1:0]),
      .last_char  (req_tlast),
      .a_valid_ff (a_valid),
      .a_term_ff  (a_term)
   );

   idp_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .a_valid    (a_valid),
      .a_term     (a_term),
      .e_valid_ff (e_valid),
      .e_term_ff  (e_term)
   );

   idp_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .e_valid    (e_valid),
      .e_term     (e_term),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // an invalid result carries a zero duration and no saturation
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("invalid result with non-zero payload");

   // input held back only by a final word waiting on the result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && e_valid && e_term.ctl.last)
      else $error("input stalled without a pending result");

   // a new result only follows a final character leaving the pipeline
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(e_valid && e_term.ctl.last && adv))
      else $error("result word without a final character");

endmodule

`default_nettype wire
